/* design/accel_peak_step_detector_top_defines.svh */
// Assertion macros shared by the step detector's checker.
`ifndef ACCEL_PEAK_STEP_DETECTOR_TOP_DEFINES_SVH
`define ACCEL_PEAK_STEP_DETECTOR_TOP_DEFINES_SVH

// Property checked only outside reset.
`define APSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define APSD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/apsd_pkg.sv */
// Types and constants shared by the step detector modules.
package apsd_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_HIGH_THRESHOLD_SQ = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOW_THRESHOLD_SQ = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MIN_GAP_MS = 2'd2;

  localparam logic [31:0] HIGH_THRESHOLD_SQ_RESET = 32'd22187868;
  localparam logic [31:0] LOW_THRESHOLD_SQ_RESET = 32'd18496881;
  localparam logic [15:0] MIN_GAP_MS_RESET = 16'd250;

  // One classified sample as it travels from the front end to the back end.
  typedef struct packed {
    logic        clear;
    logic        above_high;
    logic        below_low;
    logic [31:0] time_ms;
  } sample_class_t;

endpackage

/* design/apsd_front.sv */
// Front end: accepts samples, squares the axes and classifies the magnitude.
module apsd_front #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             command,
  input  logic signed [15:0]               accel_x,
  input  logic signed [15:0]               accel_y,
  input  logic signed [15:0]               accel_z,
  input  logic [31:0]                      time_ms,
  input  logic [31:0]                      high_threshold_sq,
  input  logic [31:0]                      low_threshold_sq,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_count,
  output logic                             push,
  output apsd_pkg::sample_class_t          push_item
);
  import apsd_pkg::*;

  localparam int unsigned CountW = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [15:0] magnitude16(input logic signed [15:0] v);
    logic [15:0] raw;
    begin
      raw = v;
      magnitude16 = raw[15] ? (~raw + 16'd1) : raw;
    end
  endfunction

  logic          accept;
  logic [CountW:0] held;

  logic          s1_valid;
  logic          s1_clear;
  logic [31:0]   s1_sq_x;
  logic [31:0]   s1_sq_y;
  logic [31:0]   s1_sq_z;
  logic [31:0]   s1_time;

  logic          s2_valid;
  sample_class_t s2_item;
  logic [31:0]   sq_sum;

  // Every beat in flight has a queue slot reserved, so the pipe never stalls.
  assign held = {1'b0, queue_count} + (CountW+1)'(s1_valid) + (CountW+1)'(s2_valid);
  assign in_stall = held >= (CountW+1)'(QUEUE_DEPTH);
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_clear <= command;
      s1_sq_x <= 32'(magnitude16(accel_x)) * 32'(magnitude16(accel_x));
      s1_sq_y <= 32'(magnitude16(accel_y)) * 32'(magnitude16(accel_y));
      s1_sq_z <= 32'(magnitude16(accel_z)) * 32'(magnitude16(accel_z));
      s1_time <= time_ms;
    end
  end

  // The sum is at most 3 * 2^30 and fits 32 bits exactly.
  assign sq_sum = s1_sq_x + s1_sq_y + s1_sq_z;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_item.clear <= s1_clear;
      s2_item.above_high <= sq_sum > high_threshold_sq;
      s2_item.below_low <= sq_sum < low_threshold_sq;
      s2_item.time_ms <= s1_time;
    end
  end

  assign push = s2_valid;
  assign push_item = s2_item;

endmodule

/* design/apsd_queue.sv */
// Small FIFO of classified samples between the front and back ends.
module apsd_queue #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  apsd_pkg::sample_class_t          push_item,
  input  logic                             pop,
  output logic                             empty,
  output apsd_pkg::sample_class_t          head_item,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);
  import apsd_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CountW = $clog2(QUEUE_DEPTH + 1);

  sample_class_t      slots [QUEUE_DEPTH];
  logic [PtrW-1:0]    wr_ptr;
  logic [PtrW-1:0]    rd_ptr;

  assign empty = count == '0;
  assign head_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CountW'(1);
      end else if (pop && !push) begin
        count <= count - CountW'(1);
      end
    end
  end

endmodule

/* design/apsd_back.sv */
// Back end: detector state, step counting and the result register.
module apsd_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    queue_empty,
  input  apsd_pkg::sample_class_t head_item,
  output logic                    pop,
  input  logic [15:0]             min_gap_ms,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [31:0]             step_total,
  output logic                    step_seen,
  output logic                    is_armed
);
  import apsd_pkg::*;

  logic        armed_flag;
  logic [31:0] last_step_time;
  logic [31:0] step_count;

  logic        armed_next;
  logic [31:0] last_step_time_next;
  logic [31:0] step_count_next;
  logic        seen_next;
  logic [31:0] gap;

  assign pop = !queue_empty && (!out_valid || !out_stall);
  assign gap = head_item.time_ms - last_step_time;

  always_comb begin
    armed_next = armed_flag;
    last_step_time_next = last_step_time;
    step_count_next = step_count;
    seen_next = 1'b0;
    if (head_item.clear) begin
      step_count_next = '0;
    end else if (armed_flag && head_item.above_high && gap >= {16'd0, min_gap_ms}) begin
      if (step_count != '1) begin
        step_count_next = step_count + 32'd1;
      end
      last_step_time_next = head_item.time_ms;
      armed_next = 1'b0;
      seen_next = 1'b1;
    end else if (!armed_flag && head_item.below_low) begin
      armed_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed_flag <= 1'b1;
      last_step_time <= '0;
      step_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        armed_flag <= armed_next;
        last_step_time <= last_step_time_next;
        step_count <= step_count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      step_total <= step_count_next;
      step_seen <= seen_next;
      is_armed <= armed_next;
    end
  end

endmodule

/* design/accel_peak_step_detector_top.sv */
// Top level of the accelerometer peak step detector.
//
// Input channel: in_valid/in_stall carry one beat per sample, made of command
// (0 processes the sample, 1 clears the step count), accel_x/y/z and time_ms.
// Output channel: out_valid/out_stall carry exactly one result beat for every
// input beat, in order: step_total, step_seen and is_armed.
// A beat moves at a rising edge where valid is high and stall is low.
// The front end squares the three axes (three 16x16 multipliers), sums and
// compares against the squared thresholds in two register stages, then hands
// a classified beat to a small queue. The back end pops the queue, applies the
// armed flag, the gap test and the saturating count, and loads the result
// register. A result follows its input beat through the two front stages,
// the queue and the result register; one beat per cycle, barring stalls.
// When the receiver stalls, the queue absorbs beats already in flight and
// in_stall rises once the queue and the front stages together fill
// QUEUE_DEPTH slots. Reset empties the pipe and queue, arms the detector,
// clears the count and last step time, and restores the default thresholds.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at once.
module accel_peak_step_detector_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           command,
  input  logic signed [15:0]             accel_x,
  input  logic signed [15:0]             accel_y,
  input  logic signed [15:0]             accel_z,
  input  logic [31:0]                    time_ms,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [31:0]                    step_total,
  output logic                           step_seen,
  output logic                           is_armed,
  input  logic                           cfg_wr_en,
  input  logic [apsd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [apsd_pkg::CfgDataW-1:0]  cfg_data
);
  import apsd_pkg::*;

  // Configuration registers; an index beyond the list is ignored.
  logic [31:0] high_threshold_sq;
  logic [31:0] low_threshold_sq;
  logic [15:0] min_gap_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_threshold_sq <= HIGH_THRESHOLD_SQ_RESET;
      low_threshold_sq <= LOW_THRESHOLD_SQ_RESET;
      min_gap_ms <= MIN_GAP_MS_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_HIGH_THRESHOLD_SQ: high_threshold_sq <= cfg_data;
        CFG_LOW_THRESHOLD_SQ:  low_threshold_sq <= cfg_data;
        CFG_MIN_GAP_MS:        min_gap_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic                             push;
  sample_class_t                    push_item;
  logic                             pop;
  logic                             queue_empty;
  sample_class_t                    head_item;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_count;

  apsd_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .command          (command),
    .accel_x          (accel_x),
    .accel_y          (accel_y),
    .accel_z          (accel_z),
    .time_ms          (time_ms),
    .high_threshold_sq(high_threshold_sq),
    .low_threshold_sq (low_threshold_sq),
    .queue_count      (queue_count),
    .push             (push),
    .push_item        (push_item)
  );

  apsd_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .empty    (queue_empty),
    .head_item(head_item),
    .count    (queue_count)
  );

  apsd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .queue_empty(queue_empty),
    .head_item  (head_item),
    .pop        (pop),
    .min_gap_ms (min_gap_ms),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .step_total (step_total),
    .step_seen  (step_seen),
    .is_armed   (is_armed)
  );

endmodule

/* design/apsd_checker.sv */
// Port-level checker for the step detector and its bind to the top level.
`include "accel_peak_step_detector_top_defines.svh"

module apsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] step_total,
  input logic        step_seen,
  input logic        is_armed
);

  `APSD_ASSERT_ALWAYS(a_reset_empties_output, rst |=> !out_valid, "result beat right after reset")

  `APSD_ASSERT(a_stalled_result_holds, out_valid && out_stall |=> out_valid && $stable(step_total) && $stable(step_seen) && $stable(is_armed), "stalled result beat changed")

  `APSD_ASSERT(a_step_disarms, out_valid && step_seen |-> !is_armed, "counted step left detector armed")

  `APSD_ASSERT(a_step_nonzero_total, out_valid && step_seen |-> step_total != 32'd0, "counted step with zero total")

endmodule

bind accel_peak_step_detector_top apsd_checker u_apsd_checker (.*);

/* sim/tb_top.sv */
// Self-checking testbench for the accelerometer peak step detector top level.
`timescale 1ns / 100ps

module tb_top;
  import apsd_pkg::*;

  // Command codes carried on the command field of an input beat.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // The one register index that selects nothing; writes to it must be dropped.
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  // Largest squared magnitude a sample can produce: three axes at -32768.
  localparam logic [31:0] MAX_SQ = 32'd3221225472;

  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 12;
  localparam int SHOW_LIMIT    = 10;
  localparam int PHASE_COUNT   = 6;
  localparam int PHASE_BEATS   = 95;

  // One expected or observed result beat.
  typedef struct packed {
    logic [31:0] total;
    logic        seen;
    logic        armed;
  } step_result_t;

  // Clock, reset and everything the testbench drives start at known values.
  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                command   = CMD_SAMPLE;
  logic signed [15:0]  accel_x   = '0;
  logic signed [15:0]  accel_y   = '0;
  logic signed [15:0]  accel_z   = '0;
  logic [31:0]         time_ms   = '0;
  logic                out_stall = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  logic                in_stall;
  logic                out_valid;
  logic [31:0]         step_total;
  logic                step_seen;
  logic                is_armed;

  // Shadow copy of the detector: configuration and state as they should be.
  logic [31:0] thr_high;
  logic [31:0] thr_low;
  logic [15:0] gap_ms;
  logic        armed_now;
  logic [31:0] last_step_ms;
  logic [31:0] steps;

  // Results predicted for accepted input beats, oldest first.
  step_result_t pending_steps[$];

  // Stimulus knobs. The receiver's stall rate is changed with nonblocking
  // writes so that its own process never races the test sequence.
  int   idle_pct  = 21;
  int   stall_pct = 21;
  logic hold_off  = 1'b0;

  // Walking-pattern state used by the random stimulus.
  logic [31:0] clock_ms;
  logic        peak_next;

  // Run statistics.
  int fail_count  = 0;
  int shown       = 0;
  int beats_in    = 0;
  int results_out = 0;
  int steps_hit   = 0;
  int clears_sent = 0;
  int cfg_writes  = 0;
  int settings    = 0;

  accel_peak_step_detector_top DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .accel_x    (accel_x),
    .accel_y    (accel_y),
    .accel_z    (accel_z),
    .time_ms    (time_ms),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .step_total (step_total),
    .step_seen  (step_seen),
    .is_armed   (is_armed),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Square of one axis, taken on the magnitude so -32768 squares to 2^30.
  function automatic logic [31:0] axis_sq(input logic [15:0] a);
    logic [16:0] mag;
    logic [31:0] wide;
    mag  = a[15] ? (17'h10000 - {1'b0, a}) : {1'b0, a};
    wide = {15'd0, mag};
    return wide * wide;
  endfunction

  // Advances the shadow detector by one input beat and returns its result.
  // A clear only zeroes the count; the armed flag and last step time stay.
  // The gap is a 32-bit wrapping difference, and the count saturates.
  function automatic step_result_t count_step(input logic cmd, input logic [15:0] x,
                                              input logic [15:0] y, input logic [15:0] z,
                                              input logic [31:0] t);
    step_result_t r;
    logic [31:0]  sq;
    logic [31:0]  since;
    r.seen = 1'b0;
    if (cmd == CMD_CLEAR) begin
      steps = '0;
    end else begin
      sq    = axis_sq(x) + axis_sq(y) + axis_sq(z);
      since = t - last_step_ms;
      if (armed_now && sq > thr_high && since >= {16'd0, gap_ms}) begin
        if (steps != '1) begin
          steps = steps + 32'd1;
        end
        last_step_ms = t;
        armed_now    = 1'b0;
        r.seen       = 1'b1;
      end else if (!armed_now && sq < thr_low) begin
        armed_now = 1'b1;
      end
    end
    r.total = steps;
    r.armed = armed_now;
    return r;
  endfunction

  // Every input beat the block takes is predicted at the edge that moves it.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      pending_steps.push_back(count_step(command, accel_x, accel_y, accel_z, time_ms));
      beats_in++;
      if (command == CMD_CLEAR) begin
        clears_sent++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  // Each result beat is compared field by field with the oldest prediction.
  // A beat with nothing predicted is a failure of its own.
  always @(posedge clk) begin : check_result
    step_result_t want;
    step_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.total = step_total;
      got.seen  = step_seen;
      got.armed = is_armed;
      if (pending_steps.size() == 0) begin
        fail_count++;
        if (shown < SHOW_LIMIT) begin
          shown++;
          $display("unexpected result beat: total=%0d seen=%0b armed=%0b",
                   got.total, got.seen, got.armed);
        end
      end else begin
        want = pending_steps.pop_front();
        results_out++;
        if (want.seen) begin
          steps_hit++;
        end
        if (got.total !== want.total || got.seen !== want.seen ||
            got.armed !== want.armed) begin
          fail_count++;
          if (shown < SHOW_LIMIT) begin
            shown++;
            $display("step result mismatch at beat %0d: ", results_out,
                     "expected total=%0d seen=%0b armed=%0b, ",
                     want.total, want.seen, want.armed,
                     "got total=%0d seen=%0b armed=%0b",
                     got.total, got.seen, got.armed);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver
  // ---------------------------------------------------------------------------

  // The receiver stalls at random, or solidly while a hold-off is in force.
  always @(posedge clk) begin
    if (hold_off) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Shared driving tasks
  // ---------------------------------------------------------------------------

  // Offers one input beat and returns right after the edge that accepts it.
  // Valid is only lowered when an idle gap is actually inserted, so a
  // back-to-back beat never sees valid dropped and raised in the same step.
  task automatic send_beat(input logic cmd, input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] z, input logic [31:0] t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    accel_x  <= x;
    accel_y  <= y;
    accel_z  <= z;
    time_ms  <= t;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // Stops offering beats and waits until every predicted result has arrived.
  // The first edge lets the monitor record a beat accepted at the last one.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_steps.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Presents one register write; the enable is left high for a following
  // write, and the caller lowers it when the sequence is done.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_writes++;
    case (idx)
      CFG_HIGH_THRESHOLD_SQ: thr_high = data;
      CFG_LOW_THRESHOLD_SQ:  thr_low  = data;
      CFG_MIN_GAP_MS:        gap_ms   = data[15:0];
      default: ;
    endcase
  endtask

  // Writes all three registers while the block is idle. Only the low half
  // of the gap word is meaningful, so random upper bits are fine there.
  task automatic apply_config(input logic [31:0] hi, input logic [31:0] lo,
                              input logic [31:0] gap_word);
    drain();
    write_reg(CFG_HIGH_THRESHOLD_SQ, hi);
    write_reg(CFG_LOW_THRESHOLD_SQ, lo);
    write_reg(CFG_MIN_GAP_MS, gap_word);
    cfg_wr_en <= 1'b0;
    settings++;
  endtask

  // One axis value whose square is close to the target, with a random sign.
  function automatic logic [15:0] axis_for(input logic [31:0] target);
    int mag;
    mag = int'($sqrt(real'(target))) + int'($urandom_range(2)) - 1;
    if (mag > 32767) begin
      mag = 32767;
    end else if (mag < 0) begin
      mag = 0;
    end
    return 16'($urandom_range(1) ? -mag : mag);
  endfunction

  // One beat of a walking pattern: peaks above the high threshold alternate
  // with troughs below the low one, timestamps advance on the order of the
  // minimum gap, and some beats are clears, time jumps or plain noise.
  task automatic send_walk_beat;
    logic [33:0] target;
    logic [31:0] span;
    logic [15:0] ax[3];
    int          roll;
    int          big;
    roll = $urandom_range(99);
    if (roll < 3) begin
      send_beat(CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
    end else if (roll < 18) begin
      send_beat(($urandom_range(9) == 0) ? CMD_CLEAR : CMD_SAMPLE,
                16'($urandom), 16'($urandom), 16'($urandom),
                $urandom_range(1) ? $urandom : clock_ms);
    end else begin
      if (peak_next) begin
        span   = $urandom_range(thr_high / 8 + 64);
        target = {2'b00, thr_high} + {2'b00, span};
        if (target > {2'b00, MAX_SQ}) begin
          target = {2'b00, MAX_SQ};
        end
      end else begin
        span   = $urandom_range(thr_low / 4 + 64);
        target = (thr_low > span) ? {2'b00, thr_low - span} : '0;
      end
      big = $urandom_range(2);
      for (int i = 0; i < 3; i++) begin
        ax[i] = (i == big) ? axis_for(target[31:0]) : 16'($urandom_range(96)) - 16'd48;
      end
      if ($urandom_range(99) < 4) begin
        clock_ms = $urandom;
      end else begin
        clock_ms = clock_ms + $urandom_range(2 * gap_ms + 40);
      end
      send_beat(CMD_SAMPLE, ax[0], ax[1], ax[2], clock_ms);
      if ($urandom_range(99) < 85) begin
        peak_next = ~peak_next;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset thresholds (1.15 g and 1.05 g squared) with the 250 ms gap: a peak
  // too soon after reset, a counted step, the disarmed state, re-arming, a
  // gap one short and one exactly met, a clear, and the axis extremes.
  task automatic test_default_thresholds;
    send_beat(CMD_SAMPLE, 16'd0, 16'd0, 16'd4096, 32'd0);
    send_beat(CMD_SAMPLE, 16'd0, 16'd0, 16'd4915, 32'd0);
    send_beat(CMD_SAMPLE, 16'd0, 16'd0, 16'd4915, 32'd300);
    send_beat(CMD_SAMPLE, 16'd0, 16'd0, 16'd4915, 32'd400);
    send_beat(CMD_SAMPLE, 16'd0, 16'd0, -16'sd4096, 32'd450);
    send_beat(CMD_SAMPLE, 16'd0, 16'd0, 16'd4915, 32'd549);
    send_beat(CMD_SAMPLE, 16'd0, 16'd0, 16'd4915, 32'd550);
    send_beat(CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
    send_beat(CMD_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 32'd60000);
    send_beat(CMD_SAMPLE, 16'h7fff, 16'h7fff, 16'h7fff, 32'hffff_ffff);
    send_beat(CMD_SAMPLE, 16'd0, 16'd0, 16'd0, 32'd61000);
  endtask

  // The gap is measured modulo 2^32: a step just before the counter wraps
  // and another just after it, then a peak that comes too soon.
  task automatic test_timestamp_wrap;
    send_beat(CMD_SAMPLE, 16'd0, -16'sd5000, 16'd0, 32'hffff_ff00);
    send_beat(CMD_SAMPLE, 16'd0, 16'd100, 16'd0, 32'hffff_ff80);
    send_beat(CMD_SAMPLE, 16'd5000, 16'd0, 16'd0, 32'h0000_0010);
    send_beat(CMD_SAMPLE, 16'd0, 16'd0, 16'd10, 32'h0000_0018);
    send_beat(CMD_SAMPLE, 16'd0, 16'd0, 16'd5000, 32'h0000_0020);
  endtask

  // Thresholds set to exact squares so that a magnitude equal to a
  // threshold can be shown to neither count nor re-arm; a zero gap lets a
  // step follow at the same timestamp.
  task automatic test_threshold_edges;
    apply_config(32'd24157225, 32'd16777216, 32'd0);
    send_beat(CMD_SAMPLE, 16'd0, 16'd0, 16'd4915, 32'd1000);
    send_beat(CMD_SAMPLE, 16'd0, 16'd0, -16'sd4916, 32'd1000);
    send_beat(CMD_SAMPLE, 16'd4096, 16'd0, 16'd0, 32'd1000);
    send_beat(CMD_SAMPLE, 16'd4095, 16'd0, 16'd0, 32'd1000);
    send_beat(CMD_SAMPLE, 16'd0, 16'd4916, 16'd0, 32'd1000);
  endtask

  // Register extremes: thresholds of all ones never let a step count, a
  // high threshold just under the largest magnitude does, and a low
  // threshold above the high one makes every small sample re-arm.
  task automatic test_extreme_config;
    apply_config(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(CMD_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 32'h8000_0000);
    send_beat(CMD_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 32'h0000_0000);
    apply_config(MAX_SQ - 1, 32'd0, 32'hffff_0000);
    send_beat(CMD_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 32'h1234_5678);
    send_beat(CMD_SAMPLE, 16'd0, 16'd0, 16'd0, 32'h1234_6000);
    apply_config(32'd0, 32'hffff_ffff, 32'd0);
    send_beat(CMD_SAMPLE, 16'd0, 16'd0, 16'd0, 32'd7);
    send_beat(CMD_SAMPLE, 16'd0, 16'd0, 16'd0, 32'd8);
    send_beat(CMD_SAMPLE, 16'd1, 16'd0, 16'd0, 32'd9);
    send_beat(CMD_SAMPLE, 16'd0, 16'd0, 16'd1, 32'd9);
  endtask

  // A write to the unused register index must leave every setting alone.
  task automatic test_unused_index;
    apply_config(HIGH_THRESHOLD_SQ_RESET, LOW_THRESHOLD_SQ_RESET, {16'd0, MIN_GAP_MS_RESET});
    drain();
    write_reg(CFG_UNUSED, $urandom);
    cfg_wr_en <= 1'b0;
    send_beat(CMD_SAMPLE, 16'd0, 16'd0, 16'd6000, 32'd100000);
    send_beat(CMD_SAMPLE, 16'd0, 16'd0, 16'd0, 32'd100001);
  endtask

  // The receiver holds off for a long stretch while the sender offers beats
  // back to back, so the queue fills and the block must stall its input.
  task automatic test_output_hold_off;
    idle_pct  = 0;
    clock_ms  = 32'd200000;
    peak_next = 1'b1;
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
      begin
        for (int i = 0; i < 30; i++) begin
          send_walk_beat();
        end
      end
    join
    idle_pct = 21;
  endtask

  // Random walking patterns under a series of settings: the defaults, a run
  // with no idling on either side and a random gap, random thresholds around
  // one g, random thresholds with no gap, the largest gap, and a low
  // threshold above the high one.
  task automatic test_random_walks;
    logic [31:0] hi;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: apply_config(HIGH_THRESHOLD_SQ_RESET, LOW_THRESHOLD_SQ_RESET,
                        {16'd0, MIN_GAP_MS_RESET});
        1: apply_config(HIGH_THRESHOLD_SQ_RESET, LOW_THRESHOLD_SQ_RESET,
                        $urandom_range(1) ? $urandom : $urandom_range(600));
        2: begin
          hi = 32'd16777216 + $urandom_range(1 << 26);
          apply_config(hi, hi - $urandom_range(hi / 4), $urandom_range(1000));
        end
        3: begin
          hi = $urandom_range(MAX_SQ);
          apply_config(hi, $urandom_range(hi), 32'd0);
        end
        4: apply_config(HIGH_THRESHOLD_SQ_RESET, LOW_THRESHOLD_SQ_RESET, 32'h0000_ffff);
        default: begin
          hi = $urandom_range(1 << 26);
          apply_config(hi, hi + $urandom_range(1 << 26), $urandom_range(300));
        end
      endcase
      if (phase == 1) begin
        idle_pct  = 0;
        stall_pct <= 0;
      end else begin
        idle_pct  = 21;
        stall_pct <= 21;
      end
      clock_ms  = $urandom;
      peak_next = 1'($urandom_range(1));
      for (int i = 0; i < PHASE_BEATS; i++) begin
        send_walk_beat();
      end
    end
    idle_pct  = 21;
    stall_pct <= 21;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    // The shadow detector starts from its reset state.
    thr_high     = HIGH_THRESHOLD_SQ_RESET;
    thr_low      = LOW_THRESHOLD_SQ_RESET;
    gap_ms       = MIN_GAP_MS_RESET;
    armed_now    = 1'b1;
    last_step_ms = '0;
    steps        = '0;
    clock_ms     = '0;
    peak_next    = 1'b1;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_thresholds();
    test_timestamp_wrap();
    test_threshold_edges();
    test_extreme_config();
    test_unused_index();
    test_output_hold_off();
    test_random_walks();

    // Let the last results come out, then give the block a few more cycles
    // so that any stray beat would still be caught.
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_steps.size() != 0) begin
      fail_count++;
    end

    $display("Sent %0d sample beats (%0d clears) ", beats_in, clears_sent,
             "and checked %0d results; %0d steps counted.", results_out, steps_hit);
    $display("Made %0d register writes over %0d settings, ", cfg_writes, settings,
             "with random idling and a long output hold-off.");
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far longer than the slowest correct run could take.
  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
